// ===== design/stma_pkg.sv =====
// Shared types and constants for the sparse triplet matrix adder.
// Used by stma_merge, sparse_triplet_matrix_add_top and stma_checker.
package stma_pkg;

   localparam int MODE_W      = 2;
   localparam int VALUE_W     = 32;
   localparam int SUM_W       = 33;
   localparam int OUT_COORD_W = 8;

   // Operation codes carried in the mode field
   localparam logic [MODE_W-1:0] MODE_LOAD_FIRST  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD_SECOND = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ADD         = 2'd2;

   // Control from the load side to the merge sequencer
   typedef struct packed {
      logic start;
      logic overflow;
   } merge_ctl_type;

   // Status from the merge sequencer back to the load side
   typedef struct packed {
      logic busy;
      logic done;
   } merge_status_type;

endpackage

// ===== design/stma_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for both triplet lists.
module stma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write on request, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/stma_merge.sv =====
// Merge sequencer: walks both triplet lists in row-major order, adds matching
// coordinates, holds one pending result to mark the last one, drives the
// output register. Depends on stma_pkg.
module stma_merge #(
   parameter int CAPACITY   = 16,
   parameter int COORD_BITS = 8,
   localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CNTW  = $clog2(CAPACITY + 1),
   localparam int ENT_W = 2 * COORD_BITS + stma_pkg::VALUE_W
) (
   input  logic                              clock,
   input  logic                              reset,
   input  stma_pkg::merge_ctl_type           ctl,
   output stma_pkg::merge_status_type        status,
   input  logic [CNTW-1:0]                   first_count,
   input  logic [CNTW-1:0]                   second_count,
   output logic [AW-1:0]                     first_rd_addr,
   output logic [AW-1:0]                     second_rd_addr,
   input  logic [ENT_W-1:0]                  first_rd_data,
   input  logic [ENT_W-1:0]                  second_rd_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [stma_pkg::OUT_COORD_W-1:0]  rsp_out_row,
   output logic [stma_pkg::OUT_COORD_W-1:0]  rsp_out_col,
   output logic signed [stma_pkg::SUM_W-1:0] rsp_sum_value,
   output logic                              rsp_entry_valid,
   output logic                              rsp_last_entry,
   output logic                              rsp_load_overflow
);
   import stma_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_PRIME = 3'b010,
      ST_STEP  = 3'b100
   } merge_state_type;

   merge_state_type state_ff, state_in;

   logic [CNTW-1:0] i_ff, i_in, j_ff, j_in;
   logic            ovf_ff, ovf_in;

   logic                  pend_valid_ff, pend_valid_in;
   logic [COORD_BITS-1:0] pend_row_ff, pend_row_in;
   logic [COORD_BITS-1:0] pend_col_ff, pend_col_in;
   logic [SUM_W-1:0]      pend_val_ff, pend_val_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OUT_COORD_W-1:0] rsp_row_ff, rsp_row_in;
   logic [OUT_COORD_W-1:0] rsp_col_ff, rsp_col_in;
   logic [SUM_W-1:0]       rsp_val_ff, rsp_val_in;
   logic                   rsp_entry_ff, rsp_entry_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   logic [COORD_BITS-1:0] a_row, a_col, b_row, b_col;
   logic [VALUE_W-1:0]    a_val, b_val;
   logic [SUM_W-1:0]      a_ext, b_ext, pair_sum;
   logic                  a_ok, b_ok, a_first, b_first;
   logic                  take_a, take_b, cand_gen, finish, slot_free, step;
   logic [COORD_BITS-1:0] cand_row, cand_col;
   logic [SUM_W-1:0]      cand_val;

   // Split the list heads; read data always matches the current indexes
   assign a_row = first_rd_data[ENT_W-1 -: COORD_BITS];
   assign a_col = first_rd_data[VALUE_W +: COORD_BITS];
   assign a_val = first_rd_data[VALUE_W-1:0];
   assign b_row = second_rd_data[ENT_W-1 -: COORD_BITS];
   assign b_col = second_rd_data[VALUE_W +: COORD_BITS];
   assign b_val = second_rd_data[VALUE_W-1:0];

   assign a_ext    = {a_val[VALUE_W-1], a_val};
   assign b_ext    = {b_val[VALUE_W-1], b_val};
   assign pair_sum = a_ext + b_ext;

   assign a_ok    = (i_ff < first_count);
   assign b_ok    = (j_ff < second_count);
   assign a_first = (a_row < b_row) || ((a_row == b_row) && (a_col < b_col));
   assign b_first = (b_row < a_row) || ((b_row == a_row) && (b_col < a_col));
   assign finish  = !a_ok && !b_ok;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign step      = (state_ff == ST_STEP) && slot_free;

   // Pick the next merge candidate
   always_comb begin
      take_a   = 1'b0;
      take_b   = 1'b0;
      cand_gen = 1'b0;
      cand_row = a_row;
      cand_col = a_col;
      cand_val = a_ext;
      if (a_ok && b_ok) begin
         if (a_first) begin
            take_a   = 1'b1;
            cand_gen = 1'b1;
         end else if (b_first) begin
            take_b   = 1'b1;
            cand_gen = 1'b1;
            cand_row = b_row;
            cand_col = b_col;
            cand_val = b_ext;
         end else begin
            take_a   = 1'b1;
            take_b   = 1'b1;
            cand_val = pair_sum;
            cand_gen = (pair_sum != '0);
         end
      end else if (a_ok) begin
         take_a   = 1'b1;
         cand_gen = 1'b1;
      end else if (b_ok) begin
         take_b   = 1'b1;
         cand_gen = 1'b1;
         cand_row = b_row;
         cand_col = b_col;
         cand_val = b_ext;
      end
   end

   // Sequence state, indexes and captured overflow flag
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      ovf_in   = ovf_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               state_in = ST_PRIME;
               ovf_in   = ctl.overflow;
            end
         end
         ST_PRIME: begin
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (step) begin
               if (finish) begin
                  state_in = ST_IDLE;
                  i_in     = '0;
                  j_in     = '0;
               end else begin
                  i_in = i_ff + CNTW'(take_a);
                  j_in = j_ff + CNTW'(take_b);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            i_in     = '0;
            j_in     = '0;
         end
      endcase
   end

   // Pending result and output register
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_row_in   = pend_row_ff;
      pend_col_in   = pend_col_ff;
      pend_val_in   = pend_val_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_val_in    = rsp_val_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      if (slot_free) begin
         rsp_valid_in = 1'b0;
      end
      if (step) begin
         if (finish) begin
            // Flush the pending result as last, or mark an empty sum
            pend_valid_in = 1'b0;
            rsp_valid_in  = 1'b1;
            rsp_last_in   = 1'b1;
            rsp_ovf_in    = ovf_ff;
            rsp_entry_in  = pend_valid_ff;
            rsp_row_in    = pend_valid_ff ? OUT_COORD_W'(pend_row_ff) : '0;
            rsp_col_in    = pend_valid_ff ? OUT_COORD_W'(pend_col_ff) : '0;
            rsp_val_in    = pend_valid_ff ? pend_val_ff : '0;
         end else if (cand_gen) begin
            // Advance the pending result to the output
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b0;
               rsp_ovf_in   = ovf_ff;
               rsp_entry_in = 1'b1;
               rsp_row_in   = OUT_COORD_W'(pend_row_ff);
               rsp_col_in   = OUT_COORD_W'(pend_col_ff);
               rsp_val_in   = pend_val_ff;
            end
            pend_valid_in = 1'b1;
            pend_row_in   = cand_row;
            pend_col_in   = cand_col;
            pend_val_in   = cand_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         i_ff          <= '0;
         j_ff          <= '0;
         ovf_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         ovf_ff        <= ovf_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_row_ff  <= pend_row_in;
      pend_col_ff  <= pend_col_in;
      pend_val_ff  <= pend_val_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_val_ff   <= rsp_val_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // Address the RAMs with the next index so read data tracks the current one
   assign first_rd_addr  = i_in[AW-1:0];
   assign second_rd_addr = j_in[AW-1:0];

   assign status.busy = (state_ff != ST_IDLE);
   assign status.done = step && finish;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_row       = rsp_row_ff;
   assign rsp_out_col       = rsp_col_ff;
   assign rsp_sum_value     = rsp_val_ff;
   assign rsp_entry_valid   = rsp_entry_ff;
   assign rsp_last_entry    = rsp_last_ff;
   assign rsp_load_overflow = rsp_ovf_ff;

endmodule

// ===== design/sparse_triplet_matrix_add_top.sv =====
// Top level of the sparse triplet matrix adder: list counters, overflow flag,
// the two list RAMs and the merge sequencer. Depends on stma_pkg, stma_ram,
// stma_merge.
//
// Usage:
//  - req_* channel: one item per handshake (req_valid high, req_stall low).
//    Mode 0 appends (row, col, value) to the first list, mode 1 to the
//    second, mode 2 merges both lists and emits the sums, mode 3 is ignored.
//  - Loads produce no result; a load into a full list is dropped and
//    raises the sticky overflow flag reported with the next add.
//  - An add raises req_stall while the merge runs: a priming state, then a
//    step for each consumed entry (or matched pair) and a closing step; a
//    stalled output holds the steps back.
//  - rsp_*: results leave the output register in merge order, each one
//    held in the pending register until the next is known; an empty sum
//    gives one item with entry_valid low.
//  - A stalled result holds; the merge freezes until the register frees.
//  - Reset (synchronous) empties both lists, clears the overflow flag and
//    drops any pending result.
module sparse_triplet_matrix_add_top #(
   parameter int CAPACITY   = 16,
   parameter int COORD_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [stma_pkg::MODE_W-1:0]       req_mode,
   input  logic [7:0]                        req_row_index,
   input  logic [7:0]                        req_col_index,
   input  logic signed [stma_pkg::VALUE_W-1:0] req_elem_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [stma_pkg::OUT_COORD_W-1:0]  rsp_out_row,
   output logic [stma_pkg::OUT_COORD_W-1:0]  rsp_out_col,
   output logic signed [stma_pkg::SUM_W-1:0] rsp_sum_value,
   output logic                              rsp_entry_valid,
   output logic                              rsp_last_entry,
   output logic                              rsp_load_overflow
);
   import stma_pkg::*;

   localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNTW  = $clog2(CAPACITY + 1);
   localparam int ENT_W = 2 * COORD_BITS + VALUE_W;

   logic [CNTW-1:0]  first_count_ff, first_count_in;
   logic [CNTW-1:0]  second_count_ff, second_count_in;
   logic             overflow_ff, overflow_in;

   logic             accept, load_first, load_second;
   logic             first_full, second_full, first_wr, second_wr;
   logic [ENT_W-1:0] wr_entry;
   logic [AW-1:0]    first_rd_addr, second_rd_addr;
   logic [ENT_W-1:0] first_rd_data, second_rd_data;

   merge_ctl_type    ctl;
   merge_status_type status;

   assign accept      = req_valid && !req_stall;
   assign load_first  = accept && (req_mode == MODE_LOAD_FIRST);
   assign load_second = accept && (req_mode == MODE_LOAD_SECOND);
   assign first_full  = (first_count_ff == CNTW'(CAPACITY));
   assign second_full = (second_count_ff == CNTW'(CAPACITY));
   assign first_wr    = load_first && !first_full;
   assign second_wr   = load_second && !second_full;

   // Keep coordinates in their low COORD_BITS bits
   assign wr_entry = {COORD_BITS'(req_row_index), COORD_BITS'(req_col_index),
                      req_elem_value};

   // Count loads, flag dropped ones, empty the lists when a merge ends
   always_comb begin
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      overflow_in     = overflow_ff;
      if (status.done) begin
         first_count_in  = '0;
         second_count_in = '0;
         overflow_in     = 1'b0;
      end else begin
         if (first_wr) begin
            first_count_in = first_count_ff + CNTW'(1);
         end
         if (second_wr) begin
            second_count_in = second_count_ff + CNTW'(1);
         end
         if ((load_first && first_full) || (load_second && second_full)) begin
            overflow_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
         overflow_ff     <= 1'b0;
      end else begin
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         overflow_ff     <= overflow_in;
      end
   end

   assign ctl.start    = accept && (req_mode == MODE_ADD);
   assign ctl.overflow = overflow_ff;
   assign req_stall    = status.busy;

   stma_ram #(
      .WIDTH (ENT_W),
      .DEPTH (CAPACITY)
   ) u_first_ram (
      .clock   (clock),
      .wr_en   (first_wr),
      .wr_addr (first_count_ff[AW-1:0]),
      .wr_data (wr_entry),
      .rd_addr (first_rd_addr),
      .rd_data (first_rd_data)
   );

   stma_ram #(
      .WIDTH (ENT_W),
      .DEPTH (CAPACITY)
   ) u_second_ram (
      .clock   (clock),
      .wr_en   (second_wr),
      .wr_addr (second_count_ff[AW-1:0]),
      .wr_data (wr_entry),
      .rd_addr (second_rd_addr),
      .rd_data (second_rd_data)
   );

   stma_merge #(
      .CAPACITY   (CAPACITY),
      .COORD_BITS (COORD_BITS)
   ) u_merge (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .status            (status),
      .first_count       (first_count_ff),
      .second_count      (second_count_ff),
      .first_rd_addr     (first_rd_addr),
      .second_rd_addr    (second_rd_addr),
      .first_rd_data     (first_rd_data),
      .second_rd_data    (second_rd_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_sum_value     (rsp_sum_value),
      .rsp_entry_valid   (rsp_entry_valid),
      .rsp_last_entry    (rsp_last_entry),
      .rsp_load_overflow (rsp_load_overflow)
   );

endmodule

// ===== design/stma_checker.sv =====
// Port-level checks for the sparse triplet matrix adder, bound to the top.
// Depends on stma_pkg and sparse_triplet_matrix_add_top.
module stma_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic [stma_pkg::MODE_W-1:0]       req_mode,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [stma_pkg::OUT_COORD_W-1:0]  rsp_out_row,
   input logic [stma_pkg::OUT_COORD_W-1:0]  rsp_out_col,
   input logic signed [stma_pkg::SUM_W-1:0] rsp_sum_value,
   input logic                              rsp_entry_valid,
   input logic                              rsp_last_entry,
   input logic                              rsp_load_overflow
);
   import stma_pkg::*;

   // Reset leaves the block ready and with no result
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   // An add item locks the input side on the next cycle
   a_add_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_mode == MODE_ADD) |=> req_stall)
      else $error("add item did not stall input");

   // An empty-sum marker is always the final result of its run
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_entry_valid |-> rsp_last_entry)
      else $error("empty-sum item not marked last");

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_row)
         && $stable(rsp_out_col) && $stable(rsp_sum_value)
         && $stable(rsp_entry_valid) && $stable(rsp_last_entry)
         && $stable(rsp_load_overflow))
      else $error("stalled result changed");

endmodule

bind sparse_triplet_matrix_add_top stma_checker u_stma_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for sparse_triplet_matrix_add_top: drives load and add
// items, predicts the merged sum triplets and checks every result item.
// Depends on stma_pkg and the design sources only.
`timescale 1ns / 1ps

module tb_top;
   import stma_pkg::*;

   localparam int CAPACITY     = 16;
   localparam int RANDOM_ITEMS = 190;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_LIMIT  = 20000;
   localparam int TAIL_CYCLES  = 20;

   // Mode 3 has no meaning in the block and is ignored by it
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct {
      logic [7:0]  row;
      logic [7:0]  col;
      logic [31:0] value;
   } coord_entry_type;

   typedef struct {
      logic [7:0]  row;
      logic [7:0]  col;
      logic [32:0] sum;
      logic        entry_valid;
      logic        last_entry;
      logic        overflow;
   } sum_result_type;

   typedef struct {
      logic [MODE_W-1:0] mode;
      logic [7:0]        row;
      logic [7:0]        col;
      logic [31:0]       value;
      int                reps;
      bit                typed;
      sum_result_type    want;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode = '0;
   logic [7:0]  req_row_index = '0;
   logic [7:0]  req_col_index = '0;
   logic [31:0] req_elem_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_row;
   logic [7:0]  rsp_out_col;
   logic [32:0] rsp_sum_value;
   logic        rsp_entry_valid;
   logic        rsp_last_entry;
   logic        rsp_load_overflow;

   // Predicted state of the two lists
   coord_entry_type list_a[CAPACITY];
   coord_entry_type list_b[CAPACITY];
   int              count_a = 0;
   int              count_b = 0;
   logic            overflow_flag = 1'b0;

   sum_result_type   sums_due[$];
   sum_result_type   head_sum;
   sum_result_type   blank_sum;
   directed_row_type directed_rows[$];

   int mismatch_count = 0;
   int items_sent = 0;
   int gap_pct = 0;
   int stall_pct = 0;
   bit hold_off_req = 1'b0;
   bit hold_taken = 1'b0;
   int hold_left = 0;

   sparse_triplet_matrix_add_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_elem_value    (req_elem_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_sum_value     (rsp_sum_value),
      .rsp_entry_valid   (rsp_entry_valid),
      .rsp_last_entry    (rsp_last_entry),
      .rsp_load_overflow (rsp_load_overflow)
   );

   initial forever #5 clock = ~clock;

   // End the run if it hangs
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got, want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   function automatic void push_sum(input logic [7:0] row, col, input logic [32:0] s,
                                    input logic v, ovf);
      sum_result_type r;
      r.row = row;
      r.col = col;
      r.sum = s;
      r.entry_valid = v;
      r.last_entry = 1'b0;
      r.overflow = ovf;
      sums_due.push_back(r);
   endfunction

   // Apply one accepted item to the predicted lists; queue the sums it emits
   function automatic int predict_sums(input logic [1:0] mode, input logic [7:0] row, col,
                                       input logic [31:0] value);
      int          i;
      int          j;
      int          base;
      logic        ovf;
      logic [15:0] key_a;
      logic [15:0] key_b;
      logic [32:0] total;
      if (mode == MODE_LOAD_FIRST) begin
         if (count_a >= CAPACITY) overflow_flag = 1'b1;
         else begin
            list_a[count_a] = '{row, col, value};
            count_a++;
         end
         return 0;
      end
      if (mode == MODE_LOAD_SECOND) begin
         if (count_b >= CAPACITY) overflow_flag = 1'b1;
         else begin
            list_b[count_b] = '{row, col, value};
            count_b++;
         end
         return 0;
      end
      if (mode != MODE_ADD) return 0;

      // Merge in row-major order; matching coordinates add, zero sums drop
      base = sums_due.size();
      ovf = overflow_flag;
      i = 0;
      j = 0;
      while (i < count_a && j < count_b) begin
         key_a = {list_a[i].row, list_a[i].col};
         key_b = {list_b[j].row, list_b[j].col};
         if (key_a < key_b) begin
            push_sum(list_a[i].row, list_a[i].col,
                     {list_a[i].value[31], list_a[i].value}, 1'b1, ovf);
            i++;
         end else if (key_b < key_a) begin
            push_sum(list_b[j].row, list_b[j].col,
                     {list_b[j].value[31], list_b[j].value}, 1'b1, ovf);
            j++;
         end else begin
            total = {list_a[i].value[31], list_a[i].value}
                  + {list_b[j].value[31], list_b[j].value};
            if (total != '0) push_sum(list_a[i].row, list_a[i].col, total, 1'b1, ovf);
            i++;
            j++;
         end
      end
      for (; i < count_a; i++)
         push_sum(list_a[i].row, list_a[i].col, {list_a[i].value[31], list_a[i].value},
                  1'b1, ovf);
      for (; j < count_b; j++)
         push_sum(list_b[j].row, list_b[j].col, {list_b[j].value[31], list_b[j].value},
                  1'b1, ovf);
      if (sums_due.size() == base) push_sum('0, '0, '0, 1'b0, ovf);
      sums_due[sums_due.size() - 1].last_entry = 1'b1;
      count_a = 0;
      count_b = 0;
      overflow_flag = 1'b0;
      return sums_due.size() - base;
   endfunction

   // Offer one item, hold it until accepted, then predict its sums
   task automatic send_item(input logic [1:0] mode, input logic [7:0] row, col,
                            input logic [31:0] value, input bit typed,
                            input sum_result_type want);
      int n;
      int k;
      // Insert random idle gaps before the item
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_row_index <= row;
      req_col_index <= col;
      req_elem_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n = predict_sums(mode, row, col, value);
      if (typed) begin
         for (k = 0; k < n; k++) sums_due.delete(sums_due.size() - 1);
         sums_due.push_back(want);
      end
      if (mode != MODE_UNUSED) items_sent++;
   endtask

   // Lower valid and wait until every predicted sum has come out
   task automatic wait_for_sums();
      int waited;
      req_valid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (sums_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (sums_due.size() != 0) begin
         report_mismatch($sformatf("%0d sum items never arrived", sums_due.size()));
         sums_due.delete();
      end
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(8))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'($urandom_range(1, 9));
         4: return '0;
         default: return $urandom;
      endcase
   endfunction

   // Build two row-major lists with shared coordinates (the first sometimes out of order), load them and add
   task automatic send_matrix_pair();
      coord_entry_type first_q[$];
      coord_entry_type second_q[$];
      coord_entry_type e;
      coord_entry_type tmp;
      int              n_keys;
      int              pos;
      int              k;
      int              which;
      logic [31:0]     v;
      n_keys = ($urandom_range(7) == 0) ? $urandom_range(12, 22) : $urandom_range(0, 8);
      case ($urandom_range(3))
         0: pos = 0;
         1: pos = $urandom_range(60000, 65535);
         default: pos = $urandom_range(0, 2000);
      endcase
      for (k = 0; k < n_keys && pos <= 65535; k++) begin
         e.row = pos[15:8];
         e.col = pos[7:0];
         v = pick_value();
         e.value = v;
         which = $urandom_range(2);
         if (which != 1) first_q.push_back(e);
         if (which != 0) begin
            // Shared coordinate: sometimes cancel to zero
            if (which == 2) e.value = ($urandom_range(3) == 0) ? -v : pick_value();
            second_q.push_back(e);
         end
         pos += ($urandom_range(1) != 0) ? $urandom_range(1, 3) : $urandom_range(1, 9000);
      end
      // Break the ordering now and then
      if ($urandom_range(9) == 0 && first_q.size() > 1) begin
         tmp = first_q[0];
         first_q[0] = first_q[first_q.size() - 1];
         first_q[first_q.size() - 1] = tmp;
      end
      while (first_q.size() + second_q.size() > 0) begin
         if (second_q.size() == 0 || (first_q.size() != 0 && $urandom_range(1) != 0)) begin
            e = first_q.pop_front();
            send_item(MODE_LOAD_FIRST, e.row, e.col, e.value, 1'b0, blank_sum);
         end else begin
            e = second_q.pop_front();
            send_item(MODE_LOAD_SECOND, e.row, e.col, e.value, 1'b0, blank_sum);
         end
      end
      send_item(MODE_ADD, 8'($urandom), 8'($urandom), $urandom, 1'b0, blank_sum);
   endtask

   // A few items with every field random, unused mode included
   task automatic send_noise();
      int n;
      int k;
      n = $urandom_range(1, 3);
      for (k = 0; k < n; k++)
         send_item(2'($urandom_range(3)), 8'($urandom), 8'($urandom), $urandom, 1'b0,
                   blank_sum);
   endtask

   function automatic void load_row(input logic [1:0] mode, input logic [7:0] row, col,
                                    input logic [31:0] value, input int reps);
      directed_row_type d;
      d.mode = mode;
      d.row = row;
      d.col = col;
      d.value = value;
      d.reps = reps;
      d.typed = 1'b0;
      d.want = blank_sum;
      directed_rows.push_back(d);
   endfunction

   function automatic void sum_row(input bit typed, input logic [7:0] row, col,
                                   input logic [32:0] s, input logic v, ovf);
      directed_row_type d;
      d.mode = MODE_ADD;
      d.row = '0;
      d.col = '0;
      d.value = '0;
      d.reps = 1;
      d.typed = typed;
      d.want = '{row, col, s, v, 1'b1, ovf};
      directed_rows.push_back(d);
   endfunction

   // Receiver: long hold-off on request, otherwise random stalls
   always @(posedge clock) begin
      if (hold_off_req && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Compare each accepted result item with the oldest predicted sum
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sums_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result item row %0d col %0d",
                                      rsp_out_row, rsp_out_col));
         end else begin
            head_sum = sums_due.pop_front();
            check_field("out_row", 64'(rsp_out_row), 64'(head_sum.row));
            check_field("out_col", 64'(rsp_out_col), 64'(head_sum.col));
            check_field("sum_value", 64'(rsp_sum_value), 64'(head_sum.sum));
            check_field("entry_valid", 64'(rsp_entry_valid), 64'(head_sum.entry_valid));
            check_field("last_entry", 64'(rsp_last_entry), 64'(head_sum.last_entry));
            check_field("load_overflow", 64'(rsp_load_overflow), 64'(head_sum.overflow));
         end
      end
   end

   initial begin
      int r;
      int k;
      int phase;
      blank_sum = '{'0, '0, '0, 1'b0, 1'b0, 1'b0};

      // Directed table: typed sums where the answer is obvious
      sum_row(1'b1, 8'd0, 8'd0, 33'h0, 1'b0, 1'b0);                 // empty after reset
      load_row(MODE_LOAD_FIRST, 8'd0, 8'd0, 32'h8000_0000, 1);
      load_row(MODE_LOAD_SECOND, 8'd0, 8'd0, 32'h8000_0000, 1);
      sum_row(1'b1, 8'd0, 8'd0, 33'h1_0000_0000, 1'b1, 1'b0);       // most negative sum
      load_row(MODE_LOAD_FIRST, 8'd255, 8'd255, 32'h7FFF_FFFF, 1);
      load_row(MODE_LOAD_SECOND, 8'd255, 8'd255, 32'h7FFF_FFFF, 1);
      sum_row(1'b1, 8'd255, 8'd255, 33'h0_FFFF_FFFE, 1'b1, 1'b0);   // most positive sum
      load_row(MODE_LOAD_FIRST, 8'd17, 8'd34, 32'd5, 1);
      load_row(MODE_UNUSED, 8'd3, 8'd3, 32'hFFFF_FFFF, 1);
      load_row(MODE_LOAD_SECOND, 8'd17, 8'd34, 32'hFFFF_FFFB, 1);
      sum_row(1'b1, 8'd0, 8'd0, 33'h0, 1'b0, 1'b0);                 // cancels to empty
      load_row(MODE_LOAD_FIRST, 8'd1, 8'd2, 32'd0, 1);
      sum_row(1'b1, 8'd1, 8'd2, 33'h0, 1'b1, 1'b0);                 // unmatched zero value
      load_row(MODE_LOAD_FIRST, 8'd1, 8'd1, 32'd10, 1);
      load_row(MODE_LOAD_FIRST, 8'd1, 8'd3, 32'd4, 1);
      load_row(MODE_LOAD_SECOND, 8'd1, 8'd1, 32'd0, 1);
      load_row(MODE_LOAD_SECOND, 8'd1, 8'd2, 32'd6, 1);
      load_row(MODE_LOAD_SECOND, 8'd2, 8'd0, 32'hFFFF_FFFF, 1);
      sum_row(1'b0, 8'd0, 8'd0, 33'h0, 1'b0, 1'b0);
      load_row(MODE_LOAD_FIRST, 8'd9, 8'd0, 32'd1, 1);              // out of order
      load_row(MODE_LOAD_FIRST, 8'd2, 8'd0, 32'd2, 1);
      load_row(MODE_LOAD_SECOND, 8'd5, 8'd5, 32'd3, 1);
      sum_row(1'b0, 8'd0, 8'd0, 33'h0, 1'b0, 1'b0);
      load_row(MODE_LOAD_FIRST, 8'd3, 8'd0, 32'd100, CAPACITY + 1); // one too many
      load_row(MODE_LOAD_SECOND, 8'd4, 8'd0, 32'hFFFF_FF00, CAPACITY);
      sum_row(1'b0, 8'd0, 8'd0, 33'h0, 1'b0, 1'b0);                 // full lists, overflow
      sum_row(1'b1, 8'd0, 8'd0, 33'h0, 1'b0, 1'b0);                 // overflow cleared

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < directed_rows.size(); r++)
         for (k = 0; k < directed_rows[r].reps; k++)
            send_item(directed_rows[r].mode, directed_rows[r].row,
                      directed_rows[r].col + 8'(k), directed_rows[r].value + 32'(k),
                      directed_rows[r].typed, directed_rows[r].want);
      wait_for_sums();

      // Random part in idling phases, draining between them
      items_sent = 0;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               gap_pct = 0;
               stall_pct = 0;
               hold_off_req = 1'b1;
            end
            1: begin
               gap_pct = 55;
               stall_pct = 0;
            end
            2: begin
               gap_pct = 0;
               stall_pct = 55;
            end
            default: begin
               gap_pct = 16;
               stall_pct = 16;
            end
         endcase
         while (items_sent < (phase + 1) * RANDOM_ITEMS / 4) begin
            if ($urandom_range(4) == 0) send_noise();
            else send_matrix_pair();
         end
         wait_for_sums();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
